@@ hw/rtl/rrdg_pkg.sv @@
// Shared constants, register codes and pipeline sideband type for the radial ramp disk generator.
package rrdg_pkg;

    // Default values for the top-level parameters.
    localparam int COORD_BITS_DEF     = 12;
    localparam int DIST_FRAC_BITS_DEF = 8;
    localparam int OUT_BITS_DEF       = 16;

    // Fixed register widths.
    localparam int ROWS_W     = 13;
    localparam int CTR_W      = 14;
    localparam int RAD_W      = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;

    // Squared integer distances at or above 2^FAR_BITS are always outside the disk.
    localparam int FAR_BITS = 24;

    // Register reset values.
    localparam logic [ROWS_W-1:0] ROWS_RST = ROWS_W'(4096);
    localparam logic [ROWS_W-1:0] COLS_RST = ROWS_W'(4096);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_ROWS  = 3'd0,
        CFG_IMAGE_COLS  = 3'd1,
        CFG_CENTER_X    = 3'd2,
        CFG_CENTER_Y    = 3'd3,
        CFG_DISK_RADIUS = 3'd4
    } t_cfg_idx;

    // Flags that travel with each item down the pipeline.
    typedef struct packed {
        logic in_image;
        logic live;
        logic sat;
    } t_side;

endpackage

@@ hw/rtl/rrdg_if.sv @@
// Handshake channel interfaces: configuration writes, pixel requests and results.

interface rrdg_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [rrdg_pkg::CFG_IDX_W-1:0]  index;
    logic [rrdg_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

interface rrdg_pix_if #(
    parameter int COORD_BITS = rrdg_pkg::COORD_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;

    modport source (output valid, output pixel_x, output pixel_y, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface rrdg_res_if #(
    parameter int OUT_BITS = rrdg_pkg::OUT_BITS_DEF
);
    logic                valid;
    logic                ready;
    logic [OUT_BITS-1:0] intensity;
    logic                inside_disk;
    logic                inside_image;

    modport source (output valid, output intensity, output inside_disk, output inside_image,
                    input ready);
    modport sink   (input valid, input intensity, input inside_disk, input inside_image,
                    output ready);
endinterface

@@ hw/rtl/rrdg_front.sv @@
// Front stages: offset from the center, image bounds, squares and the sum of squares.
module rrdg_front #(
    parameter int COORD_BITS     = rrdg_pkg::COORD_BITS_DEF,
    parameter int DIST_FRAC_BITS = rrdg_pkg::DIST_FRAC_BITS_DEF
) (
    input  logic                                                i_clk,
    input  logic                                                i_rst_n,
    input  logic                                                i_en,
    input  logic                                                i_valid,
    input  logic [COORD_BITS-1:0]                               i_px,
    input  logic [COORD_BITS-1:0]                               i_py,
    input  logic signed [rrdg_pkg::CTR_W-1:0]                   i_center_x,
    input  logic signed [rrdg_pkg::CTR_W-1:0]                   i_center_y,
    input  logic [rrdg_pkg::ROWS_W-1:0]                         i_rows,
    input  logic [rrdg_pkg::ROWS_W-1:0]                         i_cols,
    input  logic [rrdg_pkg::RAD_W-1:0]                          i_radius,
    output logic                                                o_valid,
    output rrdg_pkg::t_side                                     o_side,
    output logic [rrdg_pkg::FAR_BITS+2*DIST_FRAC_BITS-1:0]      o_rad
);
    import rrdg_pkg::*;

    // Magnitude width covers the widest offset between a pixel and any center.
    localparam int AX_W     = ((COORD_BITS > CTR_W - 1) ? COORD_BITS : CTR_W - 1) + 1;
    localparam int DX_W     = AX_W + 1;
    localparam int SQ_W     = 2 * AX_W;
    localparam int SUM_W    = SQ_W + 1;
    localparam int RAD_IN_W = FAR_BITS + 2 * DIST_FRAC_BITS;

    logic signed [DX_W-1:0] w_pxe, w_pye, w_cxe, w_cye, w_dx, w_dy;
    logic [AX_W-1:0]        w_ax, w_ay;
    t_side                  w_side1;
    logic [SUM_W-1:0]       w_sum;
    logic                   w_far;

    logic            r1_valid, r2_valid, r3_valid;
    t_side           r1_side, r2_side, r3_side;
    logic [AX_W-1:0] r1_ax, r1_ay;
    logic [SQ_W-1:0] r2_sqx, r2_sqy;
    logic [RAD_IN_W-1:0] r3_rad;

    // Signed offsets, their magnitudes and the image bounds check.
    always_comb begin
        w_pxe = $signed({{(DX_W-COORD_BITS){1'b0}}, i_px});
        w_pye = $signed({{(DX_W-COORD_BITS){1'b0}}, i_py});
        w_cxe = DX_W'(i_center_x);
        w_cye = DX_W'(i_center_y);
        w_dx  = w_pxe - w_cxe;
        w_dy  = w_pye - w_cye;
        w_ax  = w_dx[DX_W-1] ? AX_W'(-w_dx) : AX_W'(w_dx);
        w_ay  = w_dy[DX_W-1] ? AX_W'(-w_dy) : AX_W'(w_dy);
        w_side1.in_image = (AX_W'(i_px) < AX_W'(i_cols)) && (AX_W'(i_py) < AX_W'(i_rows));
        w_side1.live     = w_side1.in_image && (i_radius != '0);
        w_side1.sat      = 1'b0;
    end

    // Sum of squares; far pixels are dropped from the disk.
    always_comb begin
        w_sum = SUM_W'(r2_sqx) + SUM_W'(r2_sqy);
        w_far = |w_sum[SUM_W-1:FAR_BITS];
    end

    // Valid bits of the three stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    // Payload of the three stages.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_side <= w_side1;
            r1_ax   <= w_ax;
            r1_ay   <= w_ay;
            r2_side <= r1_side;
            r2_sqx  <= r1_ax * r1_ax;
            r2_sqy  <= r1_ay * r1_ay;
            r3_side <= '{in_image: r2_side.in_image, live: r2_side.live && !w_far, sat: 1'b0};
            r3_rad  <= RAD_IN_W'(w_sum[FAR_BITS-1:0]) << (2 * DIST_FRAC_BITS);
        end
    end

    assign o_valid = r3_valid;
    assign o_side  = r3_side;
    assign o_rad   = r3_rad;

endmodule

@@ hw/rtl/rrdg_sqrt_cell.sv @@
// One cell of the square root row: settles one root bit from two radicand bits.
module rrdg_sqrt_cell #(
    parameter int ROOT_W = rrdg_pkg::FAR_BITS / 2 + rrdg_pkg::DIST_FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  rrdg_pkg::t_side       i_side,
    input  logic [2*ROOT_W-1:0]   i_rad,
    input  logic [ROOT_W+1:0]     i_rem,
    input  logic [ROOT_W-1:0]     i_root,
    output logic                  o_valid,
    output rrdg_pkg::t_side       o_side,
    output logic [2*ROOT_W-1:0]   o_rad,
    output logic [ROOT_W+1:0]     o_rem,
    output logic [ROOT_W-1:0]     o_root
);
    import rrdg_pkg::*;

    logic [ROOT_W+1:0] w_rem2, w_trial;
    logic              w_ge;

    // Bring down the next two radicand bits and try the root bit as one.
    always_comb begin
        w_rem2  = {i_rem[ROOT_W-1:0], i_rad[2*ROOT_W-1 -: 2]};
        w_trial = {i_root, 2'b01};
        w_ge    = (w_rem2 >= w_trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_side <= i_side;
            o_rad  <= i_rad << 2;
            o_rem  <= w_ge ? (w_rem2 - w_trial) : w_rem2;
            o_root <= {i_root[ROOT_W-2:0], w_ge};
        end
    end

endmodule

@@ hw/rtl/rrdg_div_cell.sv @@
// One cell of the divider row: settles one quotient bit by shift, compare and subtract.
module rrdg_div_cell #(
    parameter int ROOT_W   = rrdg_pkg::FAR_BITS / 2 + rrdg_pkg::DIST_FRAC_BITS_DEF,
    parameter int OUT_BITS = rrdg_pkg::OUT_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic [ROOT_W-1:0]     i_divisor,
    input  logic                  i_valid,
    input  rrdg_pkg::t_side       i_side,
    input  logic [ROOT_W-1:0]     i_rem,
    input  logic [OUT_BITS-1:0]   i_quo,
    output logic                  o_valid,
    output rrdg_pkg::t_side       o_side,
    output logic [ROOT_W-1:0]     o_rem,
    output logic [OUT_BITS-1:0]   o_quo
);
    import rrdg_pkg::*;

    logic [ROOT_W:0] w_rem2, w_diff;
    logic            w_ge;

    // Double the partial remainder and subtract the divisor when it fits.
    always_comb begin
        w_rem2 = {i_rem, 1'b0};
        w_diff = w_rem2 - {1'b0, i_divisor};
        w_ge   = (w_rem2 >= {1'b0, i_divisor});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_side <= i_side;
            o_rem  <= w_ge ? w_diff[ROOT_W-1:0] : w_rem2[ROOT_W-1:0];
            o_quo  <= {i_quo[OUT_BITS-2:0], w_ge};
        end
    end

endmodule

@@ hw/rtl/radial_ramp_disk_generator.sv @@
// Top level of the radial ramp disk generator: registers, cell rows and output skid buffer.
//
//  Channel  Direction  Payload                                  Role
//  i_cfg    in         index, data                              register writes
//  i_pix    in         pixel_x, pixel_y                         pixel requests
//  o_res    out        intensity, inside_disk, inside_image     one result per request
//
//  Throughput is one pixel per clock while i_pix.ready is high. The square root row has one
//  cell per root bit (ROOT_W = 12 + DIST_FRAC_BITS); the divider row has one cell per
//  quotient bit. Reset clears all pipeline valid bits and loads the register defaults.
//  A two-entry skid buffer holds results; i_pix.ready drops only while its second entry is
//  full, and then the whole pipeline holds. Configuration writes are always taken.
module radial_ramp_disk_generator #(
    parameter int COORD_BITS     = rrdg_pkg::COORD_BITS_DEF,
    parameter int DIST_FRAC_BITS = rrdg_pkg::DIST_FRAC_BITS_DEF,
    parameter int OUT_BITS       = rrdg_pkg::OUT_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rrdg_cfg_if.sink     i_cfg,
    rrdg_pix_if.sink     i_pix,
    rrdg_res_if.source   o_res
);
    import rrdg_pkg::*;

    localparam int ROOT_W = FAR_BITS / 2 + DIST_FRAC_BITS;

    typedef struct packed {
        logic [OUT_BITS-1:0] intensity;
        logic                inside_disk;
        logic                inside_image;
    } t_res;

    // Configuration registers.
    logic [ROWS_W-1:0]       r_rows, r_cols;
    logic signed [CTR_W-1:0] r_center_x, r_center_y;
    logic [RAD_W-1:0]        r_radius;

    logic w_en;

    // Chain wiring between cells.
    logic                w_sq_valid [0:ROOT_W];
    t_side               w_sq_side  [0:ROOT_W];
    logic [2*ROOT_W-1:0] w_sq_rad   [0:ROOT_W];
    logic [ROOT_W+1:0]   w_sq_rem   [0:ROOT_W];
    logic [ROOT_W-1:0]   w_sq_root  [0:ROOT_W];

    logic                w_dv_valid [0:OUT_BITS];
    t_side               w_dv_side  [0:OUT_BITS];
    logic [ROOT_W-1:0]   w_dv_rem   [0:OUT_BITS];
    logic [OUT_BITS-1:0] w_dv_quo   [0:OUT_BITS];

    logic [ROOT_W-1:0] w_rfix, w_d;
    logic              r_rp_valid;
    t_side             r_rp_side;
    logic [ROOT_W-1:0] r_rp_rem;

    t_res w_up;
    logic w_up_xfer;
    logic r_main_valid, r_skid_valid;
    t_res r_main, r_skid;

    // Register writes; unknown indexes are ignored.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows     <= ROWS_RST;
            r_cols     <= COLS_RST;
            r_center_x <= '0;
            r_center_y <= '0;
            r_radius   <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_IMAGE_ROWS:  r_rows     <= i_cfg.data[ROWS_W-1:0];
                CFG_IMAGE_COLS:  r_cols     <= i_cfg.data[ROWS_W-1:0];
                CFG_CENTER_X:    r_center_x <= $signed(i_cfg.data[CTR_W-1:0]);
                CFG_CENTER_Y:    r_center_y <= $signed(i_cfg.data[CTR_W-1:0]);
                CFG_DISK_RADIUS: r_radius   <= i_cfg.data[RAD_W-1:0];
                default: ;
            endcase
        end
    end

    // The pipeline moves whenever the skid entry is free.
    assign w_en        = !r_skid_valid;
    assign i_pix.ready = w_en;

    rrdg_front #(
        .COORD_BITS     (COORD_BITS),
        .DIST_FRAC_BITS (DIST_FRAC_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (i_pix.valid),
        .i_px       (i_pix.pixel_x),
        .i_py       (i_pix.pixel_y),
        .i_center_x (r_center_x),
        .i_center_y (r_center_y),
        .i_rows     (r_rows),
        .i_cols     (r_cols),
        .i_radius   (r_radius),
        .o_valid    (w_sq_valid[0]),
        .o_side     (w_sq_side[0]),
        .o_rad      (w_sq_rad[0])
    );

    assign w_sq_rem[0]  = '0;
    assign w_sq_root[0] = '0;

    // Square root row: one root bit per cell, most significant first.
    for (genvar g = 0; g < ROOT_W; g++) begin : g_sqrt
        rrdg_sqrt_cell #(
            .ROOT_W (ROOT_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_sq_valid[g]),
            .i_side  (w_sq_side[g]),
            .i_rad   (w_sq_rad[g]),
            .i_rem   (w_sq_rem[g]),
            .i_root  (w_sq_root[g]),
            .o_valid (w_sq_valid[g+1]),
            .o_side  (w_sq_side[g+1]),
            .o_rad   (w_sq_rad[g+1]),
            .o_rem   (w_sq_rem[g+1]),
            .o_root  (w_sq_root[g+1])
        );
    end

    // Rim check, center saturation and the ramp numerator.
    assign w_d    = w_sq_root[ROOT_W];
    assign w_rfix = ROOT_W'(r_radius) << DIST_FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rp_valid <= 1'b0;
        end else if (w_en) begin
            r_rp_valid <= w_sq_valid[ROOT_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rp_side.in_image <= w_sq_side[ROOT_W].in_image;
            r_rp_side.live     <= w_sq_side[ROOT_W].live && (w_d <= w_rfix);
            r_rp_side.sat      <= (w_d == '0);
            r_rp_rem           <= w_rfix - w_d;
        end
    end

    assign w_dv_valid[0] = r_rp_valid;
    assign w_dv_side[0]  = r_rp_side;
    assign w_dv_rem[0]   = r_rp_rem;
    assign w_dv_quo[0]   = '0;

    // Divider row: one quotient bit per cell.
    for (genvar g = 0; g < OUT_BITS; g++) begin : g_div
        rrdg_div_cell #(
            .ROOT_W   (ROOT_W),
            .OUT_BITS (OUT_BITS)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_en      (w_en),
            .i_divisor (w_rfix),
            .i_valid   (w_dv_valid[g]),
            .i_side    (w_dv_side[g]),
            .i_rem     (w_dv_rem[g]),
            .i_quo     (w_dv_quo[g]),
            .o_valid   (w_dv_valid[g+1]),
            .o_side    (w_dv_side[g+1]),
            .o_rem     (w_dv_rem[g+1]),
            .o_quo     (w_dv_quo[g+1])
        );
    end

    // Final result: zero outside the disk, full scale at the center.
    always_comb begin
        w_up.inside_image = w_dv_side[OUT_BITS].in_image;
        w_up.inside_disk  = w_dv_side[OUT_BITS].live;
        if (!w_dv_side[OUT_BITS].live) begin
            w_up.intensity = '0;
        end else if (w_dv_side[OUT_BITS].sat) begin
            w_up.intensity = '1;
        end else begin
            w_up.intensity = w_dv_quo[OUT_BITS];
        end
    end

    assign w_up_xfer = w_dv_valid[OUT_BITS] && w_en;

    // Output register with a skid entry behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_main_valid && !o_res.ready) begin
            if (w_up_xfer) begin
                r_skid_valid <= 1'b1;
            end
        end else if (r_skid_valid) begin
            r_main_valid <= 1'b1;
            r_skid_valid <= 1'b0;
        end else begin
            r_main_valid <= w_up_xfer;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_main_valid && !o_res.ready) begin
            if (w_up_xfer) begin
                r_skid <= w_up;
            end
        end else if (r_skid_valid) begin
            r_main <= r_skid;
        end else begin
            r_main <= w_up;
        end
    end

    assign o_res.valid        = r_main_valid;
    assign o_res.intensity    = r_main.intensity;
    assign o_res.inside_disk  = r_main.inside_disk;
    assign o_res.inside_image = r_main.inside_image;

endmodule

@@ test/tb_top.sv @@
// Testbench for the radial ramp disk generator: directed and random pixels checked against a predictor.
`timescale 1ns / 1ps

module tb_top;
    import rrdg_pkg::*;

    localparam int  COORD_MAX    = (1 << COORD_BITS_DEF) - 1;
    localparam int  IDLE_PCT     = 9;
    localparam int  HOLD_CYCLES  = 200;
    localparam int  TAIL_CYCLES  = 60;
    localparam int  STALL_LIMIT  = 3000;
    localparam int  RAND_PHASES  = 8;
    localparam int  STEADY_PHASE = 2;
    localparam int  HOLD_PHASE   = 5;
    localparam int  MAX_REPORTS  = 10;

    // One result as the block should produce it.
    typedef struct packed {
        logic [OUT_BITS_DEF-1:0] level;
        logic                    in_disk;
        logic                    in_image;
    } t_pixel_level;

    // Predicts the ramp level of each accepted pixel and checks results in order.
    class ramp_scoreboard;
        int rows;
        int cols;
        int cx;
        int cy;
        int radius;
        t_pixel_level level_q[$];
        int mismatches;
        int checked;
        int reg_writes;
        int disk_hits;
        int full_hits;
        int rim_hits;
        int off_image;

        function new();
            rows   = int'(ROWS_RST);
            cols   = int'(COLS_RST);
            cx     = 0;
            cy     = 0;
            radius = 0;
        endfunction

        // Mirror a register write; unknown indexes are dropped by the block.
        function void apply_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            reg_writes++;
            unique case (idx)
                CFG_IMAGE_ROWS:  rows   = int'(data[ROWS_W-1:0]);
                CFG_IMAGE_COLS:  cols   = int'(data[ROWS_W-1:0]);
                CFG_CENTER_X:    cx     = int'($signed(data[CTR_W-1:0]));
                CFG_CENTER_Y:    cy     = int'($signed(data[CTR_W-1:0]));
                CFG_DISK_RADIUS: radius = int'(data[RAD_W-1:0]);
                default: ;
            endcase
        endfunction

        // Floor of the square root, built one root bit at a time from the top.
        function longint floor_sqrt(longint v);
            longint root;
            longint trial;
            int     b;
            root = 0;
            for (b = 24; b >= 0; b--) begin
                trial = root | (longint'(1) << b);
                if (trial * trial <= v) begin
                    root = trial;
                end
            end
            return root;
        endfunction

        // Ramp level 1 - d/R in Q0.16 for one pixel under the current registers.
        function t_pixel_level ramp_level(logic [COORD_BITS_DEF-1:0] px,
                                          logic [COORD_BITS_DEF-1:0] py);
            t_pixel_level r;
            longint dx;
            longint dy;
            longint sq;
            longint dist_fix;
            longint rfix;
            longint q;
            r = '0;
            r.in_image = (int'(px) < cols) && (int'(py) < rows);
            if (r.in_image && radius != 0) begin
                dx = longint'(px) - longint'(cx);
                dy = longint'(py) - longint'(cy);
                if (dx < 0) dx = -dx;
                if (dy < 0) dy = -dy;
                sq = dx * dx + dy * dy;
                // Far pixels never reach the root: the radius is below 4096.
                if (sq < (longint'(1) << FAR_BITS)) begin
                    dist_fix = floor_sqrt(sq << (2 * DIST_FRAC_BITS_DEF));
                    rfix = longint'(radius) << DIST_FRAC_BITS_DEF;
                    if (dist_fix <= rfix) begin
                        q = ((rfix - dist_fix) << OUT_BITS_DEF) / rfix;
                        r.in_disk = 1'b1;
                        if (q > (longint'(1) << OUT_BITS_DEF) - 1) begin
                            r.level = '1;
                        end else begin
                            r.level = q[OUT_BITS_DEF-1:0];
                        end
                    end
                end
            end
            return r;
        endfunction

        function void note_pixel(logic [COORD_BITS_DEF-1:0] px, logic [COORD_BITS_DEF-1:0] py);
            level_q.push_back(ramp_level(px, py));
        endfunction

        function void check_result(logic [OUT_BITS_DEF-1:0] level, logic in_disk,
                                   logic in_image);
            t_pixel_level want;
            if (level_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("unexpected result: intensity %0d disk %b image %b",
                             level, in_disk, in_image);
                end
                return;
            end
            want = level_q.pop_front();
            checked++;
            if (want.in_disk) disk_hits++;
            if (want.in_disk && want.level == '1) full_hits++;
            if (want.in_disk && want.level == '0) rim_hits++;
            if (!want.in_image) off_image++;
            if (level !== want.level || in_disk !== want.in_disk
                    || in_image !== want.in_image) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("mismatch at result %0d: expected intensity %0d disk %b image %b,",
                             checked, want.level, want.in_disk, want.in_image);
                    $display("    got intensity %0d disk %b image %b",
                             level, in_disk, in_image);
                end
            end
        endfunction

        function int pending();
            return level_q.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic steady;
    logic hold_off_req;
    int   stall_cycles;
    int   settings;

    ramp_scoreboard sb;

    rrdg_cfg_if cfg_ch ();
    rrdg_pix_if #(.COORD_BITS(COORD_BITS_DEF)) pix_ch ();
    rrdg_res_if #(.OUT_BITS(OUT_BITS_DEF)) res_ch ();

    radial_ramp_disk_generator u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_pix   (pix_ch),
        .o_res   (res_ch)
    );

    // Clock with an 8 ns period.
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Watch every transfer: mirror register writes, predict pixels, check results.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                sb.apply_write(cfg_ch.index, cfg_ch.data);
            end
            if (pix_ch.valid && pix_ch.ready) begin
                sb.note_pixel(pix_ch.pixel_x, pix_ch.pixel_y);
            end
            if (res_ch.valid && res_ch.ready) begin
                sb.check_result(res_ch.intensity, res_ch.inside_disk, res_ch.inside_image);
            end
        end
        // Watchdog on cycles without any transfer.
        if ((cfg_ch.valid && cfg_ch.ready) || (pix_ch.valid && pix_ch.ready)
                || (res_ch.valid && res_ch.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
            $display("tb_top: FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Result side: random stalls, none in the steady phase, one long hold-off on request.
    initial begin
        int hold_left;
        res_ch.ready = 1'b0;
        hold_left    = 0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                res_ch.ready <= 1'b0;
                hold_left = hold_left - 1;
            end else if (hold_off_req) begin
                res_ch.ready <= 1'b0;
                hold_left    = HOLD_CYCLES - 1;
                hold_off_req = 1'b0;
            end else if (steady) begin
                res_ch.ready <= 1'b1;
            end else begin
                res_ch.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // Write one register; the channel is lowered again before the task returns.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Offer one pixel, after an occasional random gap, and wait for its transfer.
    task automatic send_pixel(input int x, input int y);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            pix_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_ch.valid   <= 1'b1;
        pix_ch.pixel_x <= COORD_BITS_DEF'(x);
        pix_ch.pixel_y <= COORD_BITS_DEF'(y);
        @(posedge i_clk);
        while (!pix_ch.ready) @(posedge i_clk);
    endtask

    // Stop offering pixels and wait until every expected result has come back.
    task automatic drain_results();
        pix_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Write a full register setting.
    task automatic load_setting(input int rows, input int cols, input int cx, input int cy,
                                input int radius);
        write_reg(CFG_IMAGE_ROWS, CFG_DATA_W'(rows));
        write_reg(CFG_IMAGE_COLS, CFG_DATA_W'(cols));
        write_reg(CFG_CENTER_X, CFG_DATA_W'(cx));
        write_reg(CFG_CENTER_Y, CFG_DATA_W'(cy));
        write_reg(CFG_DISK_RADIUS, CFG_DATA_W'(radius));
        settings++;
    endtask

    function automatic int clamp_coord(int v);
        if (v < 0) return 0;
        if (v > COORD_MAX) return COORD_MAX;
        return v;
    endfunction

    // Random setting that favors small disks inside the image, with the extremes mixed in.
    task automatic random_setting();
        int rows;
        int cols;
        int cx;
        int cy;
        int radius;
        logic [CFG_DATA_W-1:0] raw;
        case ($urandom_range(0, 7))
            0: rows = 1;
            1: rows = 4096;
            2: rows = 8191;
            3: rows = 0;
            default: rows = $urandom_range(1, 4096);
        endcase
        case ($urandom_range(0, 6))
            0: cols = 1;
            1: cols = 4096;
            2: cols = 8191;
            default: cols = $urandom_range(1, 4096);
        endcase
        case ($urandom_range(0, 5))
            0: cx = -4096;
            1: cx = 8191;
            2: cx = int'($signed(CFG_DATA_W'($urandom)));
            default: cx = (cols > 0) ? $urandom_range(0, cols - 1) : 0;
        endcase
        case ($urandom_range(0, 5))
            0: cy = -4096;
            1: cy = 8191;
            2: cy = int'($signed(CFG_DATA_W'($urandom)));
            default: cy = (rows > 0) ? $urandom_range(0, rows - 1) : 0;
        endcase
        case ($urandom_range(0, 7))
            0: radius = 1;
            1: radius = 4095;
            2: radius = 0;
            3: radius = $urandom_range(0, 4095);
            default: radius = $urandom_range(1, 64);
        endcase
        // Bits above each register's width are ignored; drive them at random.
        write_reg(CFG_IMAGE_ROWS, {1'($urandom), ROWS_W'(rows)});
        write_reg(CFG_IMAGE_COLS, {1'($urandom), ROWS_W'(cols)});
        write_reg(CFG_CENTER_X, CFG_DATA_W'(cx));
        write_reg(CFG_CENTER_Y, CFG_DATA_W'(cy));
        write_reg(CFG_DISK_RADIUS, {2'($urandom), RAD_W'(radius)});
        if ($urandom_range(0, 1) == 1) begin
            raw = CFG_DATA_W'($urandom);
            write_reg(CFG_IDX_W'($urandom_range(CFG_DISK_RADIUS + 1, (1 << CFG_IDX_W) - 1)),
                      raw);
        end
        settings++;
    endtask

    // Pixel mostly near the disk, sometimes anywhere in the image or anywhere at all.
    task automatic random_pixel();
        int mode;
        int span;
        int x;
        int y;
        mode = $urandom_range(0, 9);
        if (mode < 2) begin
            x = $urandom_range(0, COORD_MAX);
            y = $urandom_range(0, COORD_MAX);
        end else if (mode < 4) begin
            x = (sb.cols > 0) ? $urandom_range(0, clamp_coord(sb.cols - 1)) : 0;
            y = (sb.rows > 0) ? $urandom_range(0, clamp_coord(sb.rows - 1)) : 0;
        end else begin
            span = sb.radius + 2;
            x = clamp_coord(sb.cx + int'($urandom_range(0, 2 * span)) - span);
            y = clamp_coord(sb.cy + int'($urandom_range(0, 2 * span)) - span);
        end
        send_pixel(x, y);
    endtask

    // Main sequence: reset, directed cases, then random phases.
    initial begin
        int ph;
        int count;
        sb            = new();
        i_rst_n       = 1'b0;
        steady        = 1'b0;
        hold_off_req  = 1'b0;
        stall_cycles  = 0;
        settings      = 1;
        cfg_ch.valid  = 1'b0;
        cfg_ch.index  = CFG_IMAGE_ROWS;
        cfg_ch.data   = '0;
        pix_ch.valid  = 1'b0;
        pix_ch.pixel_x = '0;
        pix_ch.pixel_y = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset setting: zero radius gives no disk anywhere.
        send_pixel(0, 0);
        send_pixel(COORD_MAX, COORD_MAX);
        send_pixel(COORD_MAX, 0);
        send_pixel(0, COORD_MAX);
        drain_results();

        // Small image with a disk of radius 10: center, rim, just past the rim, image edges.
        load_setting(64, 80, 20, 30, 10);
        write_reg(CFG_IDX_W'(CFG_DISK_RADIUS + 1), '1);
        send_pixel(20, 30);
        send_pixel(30, 30);
        send_pixel(31, 30);
        send_pixel(27, 37);
        send_pixel(79, 63);
        send_pixel(80, 30);
        send_pixel(20, 64);
        send_pixel(0, 0);
        drain_results();

        // Far corner center: squared distances beyond the root's range.
        load_setting(4096, 4096, -4096, -4096, 4095);
        send_pixel(COORD_MAX, COORD_MAX);
        send_pixel(0, 0);
        drain_results();

        // Largest radius at the origin: exact rim at the far column, just outside on the diagonal.
        load_setting(4096, 4096, 0, 0, 4095);
        send_pixel(0, 0);
        send_pixel(COORD_MAX, 0);
        send_pixel(2896, 2896);
        send_pixel(COORD_MAX, COORD_MAX);
        drain_results();

        // Empty image, then a one-pixel image with radius 1.
        write_reg(CFG_IMAGE_ROWS, '0);
        send_pixel(0, 0);
        drain_results();
        load_setting(1, 1, 0, 0, 1);
        send_pixel(0, 0);
        send_pixel(1, 0);
        drain_results();

        // Random phases; one runs without any stalls, one holds the result side off.
        for (ph = 0; ph < RAND_PHASES; ph++) begin
            random_setting();
            steady = (ph == STEADY_PHASE);
            if (ph == HOLD_PHASE) hold_off_req = 1'b1;
            count = (ph == HOLD_PHASE) ? 80 : 45;
            repeat (count) random_pixel();
            drain_results();
            steady = 1'b0;
        end

        // Let any stray result show up before the verdict.
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.pending() != 0) begin
            $display("%0d expected results never arrived", sb.pending());
        end
        $display("Checked %0d results over %0d register settings and %0d register writes.",
                 sb.checked, settings, sb.reg_writes);
        $display("Inside the disk %0d (full level %0d, on the rim %0d), outside the image %0d.",
                 sb.disk_hits, sb.full_hits, sb.rim_hits, sb.off_image);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("%0d mismatches", sb.mismatches);
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
